// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the pixel converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/rthp_pkg.sv =====
// Types and constants of the RGB to HSV pixel converter.
package rthp_pkg;

  localparam int unsigned QuotBits = 12;
  localparam int unsigned NumBits  = 20;

  localparam logic [14:0] HueFull  = 15'd23040;
  localparam logic [14:0] HueGreen = 15'd7680;
  localparam logic [14:0] HueBlue  = 15'd15360;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [NumBits-1:0]  hrem;
    logic [7:0]          hden;
    logic [QuotBits-1:0] hq;
    logic [NumBits-1:0]  srem;
    logic [7:0]          sden;
    logic [QuotBits-1:0] sq;
    logic                neg;
    sector_e             sector;
    logic [7:0]          vmax;
  } cell_t;

endpackage

// ===== design/rthp_front.sv =====
// Input stage: channel maximum and minimum, sector choice and division operands.
module rthp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  output logic            valid_o,
  input  logic            stall_i,
  output rthp_pkg::cell_t data_o
);
  import rthp_pkg::*;

  logic        valid_q;
  cell_t       data_q;
  cell_t       data_d;
  logic [7:0]  vmax;
  logic [7:0]  vmin;
  logic [7:0]  delta;
  logic [8:0]  diff;
  logic [7:0]  adiff;

  always_comb begin
    vmax = red_i;
    if (green_i > vmax) vmax = green_i;
    if (blue_i > vmax) vmax = blue_i;
    vmin = red_i;
    if (green_i < vmin) vmin = green_i;
    if (blue_i < vmin) vmin = blue_i;
    delta = vmax - vmin;

    data_d = '0;
    if (vmax == red_i) begin
      data_d.sector = SEC_RED;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (vmax == green_i) begin
      data_d.sector = SEC_GREEN;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      data_d.sector = SEC_BLUE;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end
    data_d.neg = diff[8];
    adiff = diff[8] ? 8'(-diff) : diff[7:0];

    // 3840 = 4096 - 256 and 255 = 256 - 1, so both products are shifts.
    data_d.hrem = (NumBits'(adiff) << 12) - (NumBits'(adiff) << 8);
    data_d.hden = (delta == 8'd0) ? 8'd1 : delta;
    data_d.srem = (NumBits'(delta) << 8) - NumBits'(delta);
    data_d.sden = (vmax == 8'd0) ? 8'd1 : vmax;
    data_d.vmax = vmax;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/rthp_div_cell.sv =====
// One restoring-division cell: settles one quotient bit of hue and saturation.
module rthp_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  rthp_pkg::cell_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output rthp_pkg::cell_t data_o
);
  import rthp_pkg::*;

  logic               valid_q;
  cell_t              data_q;
  cell_t              data_d;
  logic [NumBits-1:0] hsub;
  logic [NumBits-1:0] ssub;

  always_comb begin
    hsub   = NumBits'(data_i.hden) << BIT;
    ssub   = NumBits'(data_i.sden) << BIT;
    data_d = data_i;
    if (data_i.hrem >= hsub) begin
      data_d.hrem    = data_i.hrem - hsub;
      data_d.hq[BIT] = 1'b1;
    end
    if (data_i.srem >= ssub) begin
      data_d.srem    = data_i.srem - ssub;
      data_d.sq[BIT] = 1'b1;
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/rgb_to_hsv_pixel_core.sv =====
// Top level of the RGB to HSV pixel converter.
//
// The input channel carries one 8-bit RGB pixel per transfer on red_i, green_i
// and blue_i, qualified by in_valid_i; the block pushes back with in_stall_o.
// The output channel carries hue_o (1/64 degree, 0 to 23039), saturation_o and
// brightness_o, qualified by out_valid_o and held back by out_stall_i.
// A pixel passes an input stage, a row of twelve division cells and an output
// register. Each cell settles one quotient bit of both divisions, hue and
// saturation, and hands its partial remainders to the next cell, so while the
// receiver does not stall one pixel enters and one result leaves in every
// cycle: the sustained rate is one pixel per clock.
// Every stage holds its own valid flag; a stage only stalls when it is full
// and the stage after it stalls, so bubbles in the row are squeezed out and a
// new pixel is taken while a finished result still waits at the output.
// When the receiver stalls, the output register holds its result unchanged
// and the row fills up; in_stall_o rises only once every stage is occupied.
// Reset clears all valid flags, so the row starts empty; the pixel data
// registers are not reset.
module rgb_to_hsv_pixel_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] hue_o,
  output logic [7:0]  saturation_o,
  output logic [7:0]  brightness_o
);
  import rthp_pkg::*;
  `include "assert_macros.svh"

  // Stage 0 is the input stage; stage k+1 is the cell for quotient bit
  // QuotBits-1-k, so the most significant bit is settled first.
  logic  stage_valid [QuotBits+1];
  logic  stage_stall [QuotBits+1];
  cell_t stage_data  [QuotBits+1];

  logic        out_valid_q;
  logic [14:0] hue_q;
  logic [14:0] hue_d;
  logic [7:0]  sat_q;
  logic [7:0]  bright_q;
  logic [12:0] hmag;
  logic        out_hold;

  rthp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (stage_valid[0]),
    .stall_i (stage_stall[0]),
    .data_o  (stage_data[0])
  );

  for (genvar k = 0; k < QuotBits; k++) begin : g_cell
    rthp_div_cell #(
      .BIT (QuotBits - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .stall_o (stage_stall[k]),
      .data_i  (stage_data[k]),
      .valid_o (stage_valid[k+1]),
      .stall_i (stage_stall[k+1]),
      .data_o  (stage_data[k+1])
    );
  end

  // The last cell hands over to the output register.
  assign out_hold                = out_valid_q && out_stall_i;
  assign stage_stall[QuotBits]   = out_hold;

  // The quotient is the magnitude rounded down; a negative difference must
  // round towards minus infinity, hence one more when a remainder is left.
  always_comb begin
    hmag = 13'(stage_data[QuotBits].hq)
         + 13'(stage_data[QuotBits].hrem != '0);
    case (stage_data[QuotBits].sector)
      SEC_RED: begin
        hue_d = stage_data[QuotBits].neg ? (HueFull - 15'(hmag)) : 15'(hmag);
      end
      SEC_GREEN: begin
        hue_d = stage_data[QuotBits].neg ? (HueGreen - 15'(hmag))
                                         : (HueGreen + 15'(stage_data[QuotBits].hq));
      end
      SEC_BLUE: begin
        hue_d = stage_data[QuotBits].neg ? (HueBlue - 15'(hmag))
                                         : (HueBlue + 15'(stage_data[QuotBits].hq));
      end
      default: begin
        hue_d = '0;
      end
    endcase
    // A positive difference uses the plain rounded-down quotient.
    if (!stage_data[QuotBits].neg && stage_data[QuotBits].sector == SEC_RED) begin
      hue_d = 15'(stage_data[QuotBits].hq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= stage_valid[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold) begin
      hue_q    <= hue_d;
      sat_q    <= stage_data[QuotBits].sq[7:0];
      bright_q <= stage_data[QuotBits].vmax;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

  `ASSERT_ALWAYS(a_hue_range, clk_i, rst_ni, out_valid_o |-> (hue_o < HueFull))
  `ASSERT_ALWAYS(a_black_unsat, clk_i, rst_ni,
                 (out_valid_o && brightness_o == 8'd0) |-> (saturation_o == 8'd0))
  `ASSERT_ALWAYS(a_grey_hue, clk_i, rst_ni,
                 (out_valid_o && saturation_o == 8'd0) |-> (hue_o == 15'd0))
  `ASSERT_NEVER(a_stall_needs_full, clk_i, rst_ni, in_stall_o && !out_valid_o)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the RGB to HSV pixel converter.
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [14:0] hue_o;
  logic [7:0]  saturation_o;
  logic [7:0]  brightness_o;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

  hsv_t        hsv_queue[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_sender = 1'b1;
  bit          idle_receiver = 1'b1;
  int unsigned hold_off = 0;

  localparam int unsigned CycleLimit = 400000;

  rgb_to_hsv_pixel_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Fixed-point conversion of one pixel; ties for the maximum go red, green, blue.
  function automatic hsv_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int   mx, mn, delta, diff, offset, num, hue;
    hsv_t res;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    if (delta != 0) begin
      if (mx == r) begin
        offset = 0; diff = int'(g) - int'(b);
      end else if (mx == g) begin
        offset = 7680; diff = int'(b) - int'(r);
      end else begin
        offset = 15360; diff = int'(r) - int'(g);
      end
      num = 3840 * diff;
      // Round towards minus infinity on a negative difference.
      if (num >= 0) hue = offset + num / delta;
      else hue = offset - ((-num + delta - 1) / delta);
      if (hue < 0) hue += 23040;
    end
    res.hue = hue[14:0];
    res.sat = (mx != 0) ? 8'((255 * delta) / mx) : 8'd0;
    res.val = mx[7:0];
    return res;
  endfunction

  // Sends one pixel; the transfer is taken at the edge where the stall is low.
  // The valid stays high on return so that the next pixel can follow directly.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (idle_sender && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    hsv_queue.push_back(convert_pixel(r, g, b));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops offering pixels and waits until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hsv_queue.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall: random, or a long counted hold-off on request.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (hold_off != 0) begin
      out_stall_i <= 1'b1;
      hold_off    <= hold_off - 1;
    end else begin
      out_stall_i <= idle_receiver && ($urandom_range(99) < 28);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    hsv_t exp_hsv;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hsv_queue.size() == 0) begin
        $error("unexpected result hue=%0d", hue_o);
        fail_count++;
      end else begin
        exp_hsv = hsv_queue.pop_front();
        if (hue_o !== exp_hsv.hue) begin
          $error("hue expected %0d actual %0d", exp_hsv.hue, hue_o); fail_count++;
        end
        if (saturation_o !== exp_hsv.sat) begin
          $error("saturation expected %0d actual %0d", exp_hsv.sat, saturation_o);
          fail_count++;
        end
        if (brightness_o !== exp_hsv.val) begin
          $error("brightness expected %0d actual %0d", exp_hsv.val, brightness_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Extremes, grey, ties for the maximum and negative red-sector hues.
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd10, 8'd11);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd254, 8'd1, 8'd255);
    send_pixel(8'd7, 8'd3, 8'd5);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd1, 8'd2, 8'd3);
  endtask

  task automatic test_random(input int unsigned count);
    logic [7:0] r, g, b;
    for (int unsigned i = 0; i < count; i++) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      // Bias some pixels towards ties and small channel spreads.
      case ($urandom_range(3))
        0: g = r;
        1: b = g;
        2: b = r + 8'($urandom_range(3));
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  // Receiver holds off while pixels keep coming, so the row fills and stalls.
  task automatic test_backpressure();
    hold_off = 60;
    test_random(40);
  endtask

  // No idling on either side for a long stretch, then a full drain pause.
  task automatic test_full_rate();
    idle_sender   = 1'b0;
    idle_receiver = 1'b0;
    test_random(300);
    idle_sender   = 1'b1;
    idle_receiver = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    test_full_rate();
    test_random(600);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && hsv_queue.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
